FILE: src/msp_pkg.sv
// Package for the MSP v2 frame receiver: header byte values, the CRC-8 DVB-S2
// polynomial, the parser state type and the one-byte CRC update function.
// Depends on nothing.
`default_nettype none

package msp_pkg;

  localparam logic [7:0]  SOF_DOLLAR        = 8'h24;  // '$'
  localparam logic [7:0]  SOF_X             = 8'h58;  // 'X'
  localparam logic [7:0]  SOF_GT            = 8'h3E;  // '>'
  localparam logic [7:0]  CRC_POLY          = 8'hD5;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

  // Parser phases, one-hot.
  typedef enum logic [9:0] {
    PH_HUNT    = 10'b00_0000_0001,
    PH_X       = 10'b00_0000_0010,
    PH_GT      = 10'b00_0000_0100,
    PH_FLAG    = 10'b00_0000_1000,
    PH_ID_LO   = 10'b00_0001_0000,
    PH_ID_HI   = 10'b00_0010_0000,
    PH_SZ_LO   = 10'b00_0100_0000,
    PH_SZ_HI   = 10'b00_1000_0000,
    PH_PAYLOAD = 10'b01_0000_0000,
    PH_CRC     = 10'b10_0000_0000
  } phase_t;

  // CRC-8 DVB-S2 over one byte, MSB first, no reflection.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: src/msp_v2_frame_receiver_unit.sv
// Top level of the MSP v2 frame receiver: byte-wide frame parser with CRC-8
// check and a registered result stage.
// Depends on msp_pkg.
`default_nettype none

// Channel   Direction  Handshake            Payload
// rx        in         in_valid / in_stall  rx_byte
// result    out        out_valid/out_stall  kind, payload_byte, payload_index,
//                                           message_id, payload_size, crc_ok
// config    in         cfg_write            cfg_data (max_payload)
//
// One beat is taken per cycle while in_stall is low; its result, if any, appears in
// the result register on the next cycle. The parser state and the CRC update form a
// single pass of logic. Reset is synchronous and active high; it clears the parser
// state, the result valid flag and sets max_payload to 65535.
// A beat that produces no result is taken even while the result register is
// stalled; a beat that would produce a result waits only while the register is full
// and stalled.

module msp_v2_frame_receiver_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Received byte channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       payload_byte,
  output logic [15:0]      payload_index,
  output logic [15:0]      message_id,
  output logic [15:0]      payload_size,
  output logic             crc_ok,
  // Configuration
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data
);

  msp_pkg::phase_t phase, phase_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] frame_id, frame_id_next;
  logic [15:0] frame_size, frame_size_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] max_payload;

  logic        accept;
  logic        emit;        // the beat in this phase produces a result
  logic [7:0]  crc_upd;
  logic [16:0] seen_inc;

  // Whether a result comes out depends only on the stored state, so the stall
  // toward the sender never depends on the incoming byte.
  always_comb begin
    emit = 1'b0;
    if (phase == msp_pkg::PH_CRC) begin
      emit = 1'b1;
    end else if (phase == msp_pkg::PH_PAYLOAD) begin
      emit = (bytes_seen < max_payload);
    end
  end

  assign in_stall = out_valid && out_stall && emit;
  assign accept   = in_valid && !in_stall;

  assign crc_upd  = msp_pkg::crc8_step(running_crc, rx_byte);
  assign seen_inc = {1'b0, bytes_seen} + 17'd1;

  always_comb begin
    phase_next       = phase;
    running_crc_next = running_crc;
    frame_id_next    = frame_id;
    frame_size_next  = frame_size;
    bytes_seen_next  = bytes_seen;
    unique case (phase)
      msp_pkg::PH_X: begin
        phase_next = (rx_byte == msp_pkg::SOF_X) ? msp_pkg::PH_GT : msp_pkg::PH_HUNT;
      end
      msp_pkg::PH_GT: begin
        phase_next = (rx_byte == msp_pkg::SOF_GT) ? msp_pkg::PH_FLAG : msp_pkg::PH_HUNT;
      end
      msp_pkg::PH_FLAG: begin
        // The CRC restarts from zero at the flag byte.
        running_crc_next = msp_pkg::crc8_step(8'h00, rx_byte);
        phase_next       = msp_pkg::PH_ID_LO;
      end
      msp_pkg::PH_ID_LO: begin
        frame_id_next    = {8'h00, rx_byte};
        running_crc_next = crc_upd;
        phase_next       = msp_pkg::PH_ID_HI;
      end
      msp_pkg::PH_ID_HI: begin
        frame_id_next    = {rx_byte, frame_id[7:0]};
        running_crc_next = crc_upd;
        phase_next       = msp_pkg::PH_SZ_LO;
      end
      msp_pkg::PH_SZ_LO: begin
        frame_size_next  = {8'h00, rx_byte};
        running_crc_next = crc_upd;
        phase_next       = msp_pkg::PH_SZ_HI;
      end
      msp_pkg::PH_SZ_HI: begin
        frame_size_next  = {rx_byte, frame_size[7:0]};
        running_crc_next = crc_upd;
        bytes_seen_next  = 16'd0;
        // An empty payload goes straight to the CRC byte.
        phase_next = ({rx_byte, frame_size[7:0]} != 16'd0) ? msp_pkg::PH_PAYLOAD
                                                           : msp_pkg::PH_CRC;
      end
      msp_pkg::PH_PAYLOAD: begin
        running_crc_next = crc_upd;
        if (seen_inc >= {1'b0, frame_size}) begin
          phase_next = msp_pkg::PH_CRC;
        end else begin
          bytes_seen_next = seen_inc[15:0];
        end
      end
      msp_pkg::PH_CRC: begin
        phase_next = msp_pkg::PH_HUNT;
      end
      default: begin
        // Hunting, and any code without meaning, looks for the dollar sign.
        phase_next = (rx_byte == msp_pkg::SOF_DOLLAR) ? msp_pkg::PH_X : msp_pkg::PH_HUNT;
      end
    endcase
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= msp_pkg::PH_HUNT;
      running_crc <= 8'h00;
      frame_id    <= 16'd0;
      frame_size  <= 16'd0;
      bytes_seen  <= 16'd0;
    end else if (accept) begin
      phase       <= phase_next;
      running_crc <= running_crc_next;
      frame_id    <= frame_id_next;
      frame_size  <= frame_size_next;
      bytes_seen  <= bytes_seen_next;
    end
  end

  // Forwarding limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= msp_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_write) begin
      max_payload <= cfg_data;
    end
  end

  // Result register: loaded when a result-producing beat is taken, emptied when
  // the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      message_id   <= frame_id;
      payload_size <= frame_size;
      if (phase == msp_pkg::PH_CRC) begin
        kind          <= 1'b1;
        payload_byte  <= 8'h00;
        payload_index <= 16'd0;
        crc_ok        <= (rx_byte == running_crc);
      end else begin
        kind          <= 1'b0;
        payload_byte  <= rx_byte;
        payload_index <= bytes_seen;
        crc_ok        <= 1'b0;
      end
    end
  end

  // The sender is held back only while a full result register is stalled.
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // The CRC byte always yields a frame-end result on the next cycle.
  a_crc_gives_end: assert property (@(posedge clk) disable iff (rst)
    accept && phase == msp_pkg::PH_CRC |=> out_valid && kind)
    else $error("frame end result missing");

  // A forwarded payload byte carries the index it had in the parser.
  a_payload_index: assert property (@(posedge clk) disable iff (rst)
    accept && emit && phase == msp_pkg::PH_PAYLOAD
      |=> out_valid && !kind && payload_index == $past(bytes_seen))
    else $error("payload result carries wrong index");

  // A waiting result stays put while stalled.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(payload_index))
    else $error("stalled result changed");

  // Payload results never claim a CRC match.
  a_payload_no_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !crc_ok)
    else $error("payload result with crc_ok set");

endmodule

`default_nettype wire
